### rtl/pcm_pkg.sv
// shared types, constants and tables for the polyline curvature metrics block
package pcm_pkg;

	localparam int COORD_W             = 32;
	localparam int LEN_W               = 32;
	localparam int SUM_W               = 40;
	localparam int POS_W               = 16;
	localparam int STRAND_W            = 24;
	localparam int ANGLE_W             = 24;
	localparam int COORD_FRAC_BITS     = 16;
	localparam int MAX_STRAND_SEGMENTS = 65535;
	localparam int STRAND_INDEX_BITS   = 24;
	localparam int SCALED_W            = 15;
	localparam int CORDIC_STEPS        = 23;
	localparam int ROOT_STEPS          = 32;
	localparam int DIV_W               = 32 + 2 * COORD_FRAC_BITS;
	localparam int ACC_W               = 25;

	localparam logic signed [ACC_W-1:0] DEG90  = 25'sd5898240;
	localparam logic signed [ACC_W-1:0] DEG180 = 25'sd11796480;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      last_in_strand;
	} point_beat_t;

	typedef struct packed {
		logic [STRAND_W-1:0] strand_number;
		logic [POS_W-1:0]    point_position;
		logic                segment_valid;
		logic [LEN_W-1:0]    seg_length;
		logic                wedge_valid;
		logic [LEN_W-1:0]    wedge_curvature;
		logic [ANGLE_W-1:0]  wedge_turn_angle;
		logic                strand_done;
		logic [SUM_W-1:0]    strand_total_length;
		logic [POS_W-1:0]    strand_segment_count;
	} result_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIST,
		ST_ROOT,
		ST_SCALE,
		ST_WMUL,
		ST_WROOT,
		ST_PREP,
		ST_DIV,
		ST_CORDIC,
		ST_FIN
	} pcm_state_t;

	// atan(2^-i) in degrees, Q8.16
	function automatic logic signed [ACC_W-1:0] atan_deg(input logic [4:0] idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			5'd0:  v = 25'sd2949120;
			5'd1:  v = 25'sd1740967;
			5'd2:  v = 25'sd919879;
			5'd3:  v = 25'sd466945;
			5'd4:  v = 25'sd234379;
			5'd5:  v = 25'sd117304;
			5'd6:  v = 25'sd58666;
			5'd7:  v = 25'sd29335;
			5'd8:  v = 25'sd14668;
			5'd9:  v = 25'sd7334;
			5'd10: v = 25'sd3667;
			5'd11: v = 25'sd1833;
			5'd12: v = 25'sd917;
			5'd13: v = 25'sd458;
			5'd14: v = 25'sd229;
			5'd15: v = 25'sd115;
			5'd16: v = 25'sd57;
			5'd17: v = 25'sd29;
			5'd18: v = 25'sd14;
			5'd19: v = 25'sd7;
			5'd20: v = 25'sd4;
			5'd21: v = 25'sd2;
			5'd22: v = 25'sd1;
			default: v = 25'sd0;
		endcase
		return v;
	endfunction

endpackage

### rtl/polyline_curvature_metrics_top.sv
// polyline curvature metrics: segment length, menger curvature, turning angle, strand totals
//
//   channel | signals                             | carries
//   --------+-------------------------------------+-------------------------------
//   point   | point_valid, point_ready, point     | one polyline point per beat
//   result  | result_valid, result_ready, result  | one metrics record per point beat
//
// work per point: none for a strand's first point, one distance for the second, and
// two distances plus wedge math for an interior point; the 2-bit-per-cycle root unit,
// the 1-bit-per-cycle divider (64 steps) and the 23-step cordic set how long it takes.
// reset clears all strand state; no clearing pass.
// point_ready is high only while idle; a finished record waits for a free output
// register, and the output register holds while result_ready is low.
module polyline_curvature_metrics_top #(
	parameter int STRAND_INDEX_BITS = pcm_pkg::STRAND_INDEX_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	output logic                 point_ready,
	input  pcm_pkg::point_beat_t point,
	output logic                 result_valid,
	input  logic                 result_ready,
	output pcm_pkg::result_beat_t result
);
	import pcm_pkg::*;

	pcm_state_t state_q, state_d;
	logic [5:0] cnt_q;
	logic       cnt_clr;
	logic       pass_q;

	// strand state
	logic signed [COORD_W-1:0] older_x_q, older_y_q, older_z_q;
	logic signed [COORD_W-1:0] recent_x_q, recent_y_q, recent_z_q;
	logic [LEN_W-1:0]              recent_len_q;
	logic [SUM_W-1:0]              len_sum_q;
	logic [POS_W-1:0]              seen_q;
	logic [STRAND_INDEX_BITS-1:0]  strand_q;

	// per-point work registers
	point_beat_t      pt_q;
	logic [LEN_W-1:0] seg_q, chord_q, curv_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [63:0]      prod_q;
	logic [65:0]      acc_q;
	logic [63:0]      rad_q;
	logic [33:0]      rem_q;
	logic [31:0]      root_q;
	logic [SCALED_W-1:0] as_q, bs_q, cs_q;
	logic [4:0]       k_q;
	logic [31:0]      t1_q;
	logic [29:0]      c2_q, t3_q;
	logic [44:0]      d_q;
	logic [31:0]      s_q;
	logic [DIV_W-1:0] num_q, quo_q;
	logic [44:0]      drem_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [ACC_W-1:0] ang_q;

	result_beat_t out_q;
	logic         out_valid_q;

	logic seg_on, wedge_on, angle_on, slot_free, done;
	pcm_state_t dist_next_st;

	assign seg_on    = seen_q != '0;
	assign wedge_on  = seen_q >= 16'd2;
	assign angle_on  = (recent_len_q != '0) && (seg_q != '0);
	assign slot_free = !out_valid_q || result_ready;
	assign done      = pt_q.last_in_strand || (seen_q >= 16'(MAX_STRAND_SEGMENTS));

	// distance: one axis difference magnitude per cycle
	logic signed [COORD_W-1:0] p_ax, r_ax;
	logic signed [32:0]        diff;
	logic [31:0]               dmag;
	logic [65:0]               sq_sum;
	logic                      sq_sat;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				p_ax = pt_q.point_x;
				r_ax = pass_q ? older_x_q : recent_x_q;
			end
			2'd1: begin
				p_ax = pt_q.point_y;
				r_ax = pass_q ? older_y_q : recent_y_q;
			end
			default: begin
				p_ax = pt_q.point_z;
				r_ax = pass_q ? older_z_q : recent_z_q;
			end
		endcase
		diff = $signed({p_ax[COORD_W-1], p_ax}) - $signed({r_ax[COORD_W-1], r_ax});
		dmag = diff[32] ? 32'(-diff) : diff[31:0];
	end

	assign sq_sum = acc_q + {2'b00, prod_q};
	assign sq_sat = sq_sum[65:64] != 2'b00;

	// wedge side terms
	logic [15:0] sum_ab;
	logic [SCALED_W-1:0] dif_ab;
	logic signed [33:0] p_w, q_w;
	logic pq_pos;

	assign sum_ab = {1'b0, as_q} + {1'b0, bs_q};
	assign dif_ab = (as_q >= bs_q) ? (as_q - bs_q) : (bs_q - as_q);
	assign p_w    = $signed({2'b00, t1_q}) - $signed({4'b0000, c2_q});
	assign q_w    = $signed({4'b0000, c2_q}) - $signed({4'b0000, t3_q});
	assign pq_pos = (p_w > 34'sd0) && (q_w > 34'sd0);

	// shared multiplier operand select
	logic [31:0] mul_a, mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_DIST) begin
			mul_a = dmag;
			mul_b = dmag;
		end else if (state_q == ST_WMUL) begin
			case (cnt_q)
				6'd0: begin
					mul_a = 32'(sum_ab);
					mul_b = 32'(sum_ab);
				end
				6'd1: begin
					mul_a = 32'(cs_q);
					mul_b = 32'(cs_q);
				end
				6'd2: begin
					mul_a = 32'(dif_ab);
					mul_b = 32'(dif_ab);
				end
				6'd3: begin
					mul_a = 32'(as_q);
					mul_b = 32'(bs_q);
				end
				6'd4: begin
					mul_a = prod_q[31:0];
					mul_b = 32'(cs_q);
				end
				6'd5: begin
					mul_a = p_w[31:0];
					mul_b = q_w[31:0];
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	// shared root unit, two radicand bits per step
	logic [33:0] rem_t, trial;
	logic        root_ge;
	logic [33:0] rem_next;
	logic [31:0] root_next;

	assign rem_t     = {rem_q[31:0], rad_q[63:62]};
	assign trial     = {root_q, 2'b01};
	assign root_ge   = rem_t >= trial;
	assign rem_next  = root_ge ? (rem_t - trial) : rem_t;
	assign root_next = {root_q[30:0], root_ge};

	// scale the three sides down to 15 bits
	logic [31:0] side_max;
	logic [5:0]  blen;
	logic [4:0]  k_new;
	logic [31:0] a_sh, b_sh, c_sh;

	always_comb begin
		side_max = recent_len_q;
		if (seg_q > side_max) side_max = seg_q;
		if (chord_q > side_max) side_max = chord_q;
		blen = '0;
		for (int i = 0; i < 32; i++) begin
			if (side_max[i]) blen = 6'(i + 1);
		end
		k_new = (blen > 6'd15) ? 5'(blen - 6'd15) : 5'd0;
		a_sh  = recent_len_q >> k_new;
		b_sh  = seg_q >> k_new;
		c_sh  = chord_q >> k_new;
	end

	// divider step
	logic [45:0] drem_t;
	logic        div_ge;
	logic [DIV_W-1:0] quo_next;
	logic [5:0]  shift_e;

	assign drem_t   = {drem_q, num_q[DIV_W-1]};
	assign div_ge   = drem_t >= {1'b0, d_q};
	assign quo_next = {quo_q[DIV_W-2:0], div_ge};
	assign shift_e  = 6'(2 * COORD_FRAC_BITS) - {1'b0, k_q};

	// cordic start vector and step
	logic [32:0] ab_sq2;
	logic signed [35:0] x0, y0;
	logic signed [35:0] sh_x, sh_y;
	logic signed [ACC_W-1:0] ang_next;

	assign ab_sq2 = {1'b0, t1_q} + {3'b000, t3_q};
	assign x0     = $signed({6'b0, c2_q}) - $signed({4'b0, ab_sq2[32:1]});
	assign y0     = $signed({4'b0, s_q});
	assign sh_x   = cy_q >>> cnt_q[4:0];
	assign sh_y   = cx_q >>> cnt_q[4:0];
	assign ang_next = (cy_q > 36'sd0) ? (ang_q + atan_deg(cnt_q[4:0]))
	                                  : (ang_q - atan_deg(cnt_q[4:0]));

	// strand total with saturation
	logic [SUM_W:0]   total_w;
	logic [SUM_W-1:0] total;

	assign total_w = {1'b0, len_sum_q} + {9'b0, seg_q};
	assign total   = total_w[SUM_W] ? '1 : total_w[SUM_W-1:0];

	// sequencer next state
	always_comb begin
		dist_next_st = pass_q ? ST_SCALE : (wedge_on ? ST_DIST : ST_FIN);
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (point_valid) state_d = seg_on ? ST_DIST : ST_FIN;
			end
			ST_DIST: begin
				if (cnt_q == 6'd3) state_d = sq_sat ? dist_next_st : ST_ROOT;
			end
			ST_ROOT: begin
				if (cnt_q == 6'(ROOT_STEPS - 1)) state_d = dist_next_st;
			end
			ST_SCALE: begin
				state_d = ST_WMUL;
			end
			ST_WMUL: begin
				if (cnt_q == 6'd6) state_d = pq_pos ? ST_WROOT : ST_PREP;
			end
			ST_WROOT: begin
				if (cnt_q == 6'(ROOT_STEPS - 1)) state_d = ST_PREP;
			end
			ST_PREP: begin
				if (s_q != '0 && d_q != '0) state_d = ST_DIV;
				else if (angle_on) state_d = ST_CORDIC;
				else state_d = ST_FIN;
			end
			ST_DIV: begin
				if (cnt_q == 6'(DIV_W - 1)) state_d = angle_on ? ST_CORDIC : ST_FIN;
			end
			ST_CORDIC: begin
				if (cnt_q == 6'(CORDIC_STEPS - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cnt_clr = (state_d != state_q) || (state_q == ST_DIST && cnt_q == 6'd3);
	end

	assign point_ready  = state_q == ST_IDLE;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_clr ? 6'd0 : cnt_q + 6'd1;
		end
	end

	// strand state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_x_q    <= '0;
			older_y_q    <= '0;
			older_z_q    <= '0;
			recent_x_q   <= '0;
			recent_y_q   <= '0;
			recent_z_q   <= '0;
			recent_len_q <= '0;
			len_sum_q    <= '0;
			seen_q       <= '0;
			strand_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_FIN && slot_free) begin
				out_valid_q  <= 1'b1;
				older_x_q    <= recent_x_q;
				older_y_q    <= recent_y_q;
				older_z_q    <= recent_z_q;
				recent_x_q   <= pt_q.point_x;
				recent_y_q   <= pt_q.point_y;
				recent_z_q   <= pt_q.point_z;
				recent_len_q <= seg_q;
				if (done) begin
					seen_q    <= '0;
					len_sum_q <= '0;
					strand_q  <= strand_q + 1'b1;
				end else begin
					seen_q    <= seen_q + 1'b1;
					len_sum_q <= total;
				end
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output record payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			out_q.strand_number        <= STRAND_W'(strand_q);
			out_q.point_position       <= seen_q;
			out_q.segment_valid        <= seg_on;
			out_q.seg_length           <= seg_q;
			out_q.wedge_valid          <= wedge_on;
			out_q.wedge_curvature      <= curv_q;
			out_q.wedge_turn_angle     <= angle_q;
			out_q.strand_done          <= done;
			out_q.strand_total_length  <= done ? total : '0;
			out_q.strand_segment_count <= done ? seen_q : '0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (state_q == ST_IDLE && point_valid) begin
			pt_q    <= point;
			seg_q   <= '0;
			chord_q <= '0;
			curv_q  <= '0;
			angle_q <= '0;
			pass_q  <= 1'b0;
		end

		// sum of squares, then root or saturate
		if (state_q == ST_DIST) begin
			if (cnt_q == 6'd1) acc_q <= {2'b00, prod_q};
			else if (cnt_q == 6'd2) acc_q <= sq_sum;
			if (cnt_q == 6'd3) begin
				rad_q  <= sq_sum[63:0];
				rem_q  <= '0;
				root_q <= '0;
				if (sq_sat) begin
					if (pass_q) chord_q <= '1;
					else seg_q <= '1;
					pass_q <= 1'b1;
				end
			end
		end

		if (state_q == ST_ROOT || state_q == ST_WROOT) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= rem_next;
			root_q <= root_next;
			if (cnt_q == 6'(ROOT_STEPS - 1)) begin
				if (state_q == ST_WROOT) s_q <= root_next;
				else if (pass_q) chord_q <= root_next;
				else seg_q <= root_next;
				if (state_q == ST_ROOT) pass_q <= 1'b1;
			end
		end

		if (state_q == ST_SCALE) begin
			k_q  <= k_new;
			as_q <= a_sh[SCALED_W-1:0];
			bs_q <= b_sh[SCALED_W-1:0];
			cs_q <= c_sh[SCALED_W-1:0];
		end

		// products: (a+b)^2, c^2, (a-b)^2, a*b*c, P*Q
		if (state_q == ST_WMUL) begin
			case (cnt_q)
				6'd1: t1_q <= prod_q[31:0];
				6'd2: c2_q <= prod_q[29:0];
				6'd3: t3_q <= prod_q[29:0];
				6'd5: d_q  <= prod_q[44:0];
				6'd6: begin
					rad_q  <= prod_q;
					rem_q  <= '0;
					root_q <= '0;
					if (!pq_pos) s_q <= '0;
				end
				default: begin
				end
			endcase
		end

		// set up divider and cordic
		if (state_q == ST_PREP) begin
			num_q  <= DIV_W'({32'b0, s_q}) << shift_e;
			quo_q  <= '0;
			drem_q <= '0;
			if (x0 < 36'sd0) begin
				cx_q  <= y0;
				cy_q  <= -x0;
				ang_q <= DEG90;
			end else begin
				cx_q  <= x0;
				cy_q  <= y0;
				ang_q <= '0;
			end
		end

		if (state_q == ST_DIV) begin
			num_q  <= {num_q[DIV_W-2:0], 1'b0};
			quo_q  <= quo_next;
			drem_q <= div_ge ? 45'(drem_t - {1'b0, d_q}) : drem_t[44:0];
			if (cnt_q == 6'(DIV_W - 1)) begin
				curv_q <= (quo_next[DIV_W-1:LEN_W] != '0) ? '1 : quo_next[LEN_W-1:0];
			end
		end

		if (state_q == ST_CORDIC) begin
			if (cy_q > 36'sd0) begin
				cx_q <= cx_q + sh_x;
				cy_q <= cy_q - sh_y;
			end else begin
				cx_q <= cx_q - sh_x;
				cy_q <= cy_q + sh_y;
			end
			ang_q <= ang_next;
			if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
				if (ang_next < 25'sd0) angle_q <= '0;
				else if (ang_next > DEG180) angle_q <= DEG180[ANGLE_W-1:0];
				else angle_q <= ang_next[ANGLE_W-1:0];
			end
		end
	end

endmodule

### rtl/pcm_checker.sv
// port-level checks for the polyline curvature metrics block, bound to the top level
module pcm_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  point_valid,
	input logic                  point_ready,
	input pcm_pkg::point_beat_t  point,
	input logic                  result_valid,
	input logic                  result_ready,
	input pcm_pkg::result_beat_t result
);
	import pcm_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// one point in flight: not ready right after a beat is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready |=> !point_ready)
		else $error("point accepted while busy");

	// no segment means no length and no wedge
	a_seg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.segment_valid |->
			!result.wedge_valid && result.seg_length == '0)
		else $error("segment fields without a segment");

	// strand totals only on a closing beat
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.strand_done |->
			result.strand_total_length == '0 && result.strand_segment_count == '0)
		else $error("strand totals on an open strand");

	// segment count equals the closing point's position
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.strand_done |->
			result.strand_segment_count == result.point_position)
		else $error("segment count mismatch");

endmodule

bind polyline_curvature_metrics_top pcm_checker u_pcm_checker (.*);

### tb/tb.sv
// testbench for the polyline curvature metrics block: scoreboard with a built-in predictor
module tb;
	import pcm_pkg::*;

	localparam int     LIMIT_CYCLES = 4000000;
	localparam int     DRAIN_CYCLES = 400;
	localparam longint LEN32_SAT    = 64'hFFFF_FFFF;
	localparam longint LEN40_SAT    = 64'hFF_FFFF_FFFF;
	localparam longint ANGLE_90     = 5898240;
	localparam longint ANGLE_180    = 11796480;
	localparam int     ATAN_Q16 [CORDIC_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         point_valid = 1'b0;
	logic         point_ready;
	point_beat_t  point = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_beat_t result;

	// predictor state
	longint      older_x, older_y, older_z;
	longint      recent_x, recent_y, recent_z;
	logic [63:0] recent_len;
	logic [63:0] len_sum;
	int          pts_in_strand;
	logic [31:0] strand_ctr;

	result_beat_t expected_metrics [$];
	int           errors = 0;
	int           cycles = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;

	polyline_curvature_metrics_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// integer square root, floor
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] rb;
		res = '0;
		rb = 64'h4000_0000_0000_0000;
		while (rb > v)
			rb = rb >> 2;
		while (rb != 0) begin
			if (v >= res + rb) begin
				v = v - (res + rb);
				res = (res >> 1) + rb;
			end else begin
				res = res >> 1;
			end
			rb = rb >> 2;
		end
		return res;
	endfunction

	// saturating euclidean distance between two points
	function automatic logic [63:0] seg_dist(input longint ax, ay, az, bx, by, bz);
		longint      d0, d1, d2;
		logic [63:0] s, t, u, sum, tot;
		d0 = bx - ax;
		d1 = by - ay;
		d2 = bz - az;
		if (d0 < 0) d0 = -d0;
		if (d1 < 0) d1 = -d1;
		if (d2 < 0) d2 = -d2;
		s = d0 * d0;
		t = d1 * d1;
		u = d2 * d2;
		sum = s + t;
		if (sum < s)
			return LEN32_SAT;
		tot = sum + u;
		if (tot < sum)
			return LEN32_SAT;
		tot = isqrt64(tot);
		return (tot > LEN32_SAT) ? LEN32_SAT : tot;
	endfunction

	// expected metrics for one point, advances the predictor state
	function automatic result_beat_t predict_point(input point_beat_t p);
		result_beat_t r;
		longint       px, py, pz, ap, bp, cp, pp, qq, cx, cy, an, t, sx, sy;
		logic [63:0]  seg, cdist, a, b, m, s, d, q, rr, curv, ang, total;
		int           bits, k, e;
		logic         done;
		px = p.point_x;
		py = p.point_y;
		pz = p.point_z;
		done = p.last_in_strand || (pts_in_strand >= MAX_STRAND_SEGMENTS);
		seg = 0;
		curv = 0;
		ang = 0;
		if (pts_in_strand > 0)
			seg = seg_dist(recent_x, recent_y, recent_z, px, py, pz);
		// wedge at the previous point
		if (pts_in_strand >= 2) begin
			cdist = seg_dist(older_x, older_y, older_z, px, py, pz);
			a = recent_len;
			b = seg;
			m = a;
			if (b > m) m = b;
			if (cdist > m) m = cdist;
			bits = 0;
			while (bits < 64 && (m >> bits) != 0)
				bits++;
			k = (bits > SCALED_W) ? bits - SCALED_W : 0;
			ap = a >> k;
			bp = b >> k;
			cp = cdist >> k;
			pp = (ap + bp) * (ap + bp) - cp * cp;
			qq = cp * cp - (ap - bp) * (ap - bp);
			s = (pp > 0 && qq > 0) ? isqrt64(pp * qq) : 64'd0;
			d = ap * bp * cp;
			if (s != 0 && d != 0) begin
				e = 2 * COORD_FRAC_BITS - k;
				q = s / d;
				rr = s % d;
				if (e < 0) begin
					q = q >> (-e);
				end else begin
					for (int i = 0; i < e && q <= LEN32_SAT; i++) begin
						rr = rr << 1;
						q = q << 1;
						if (rr >= d) begin
							rr = rr - d;
							q = q | 64'd1;
						end
					end
				end
				curv = (q > LEN32_SAT) ? LEN32_SAT : q;
			end
			// turning angle by cordic vectoring
			if (a != 0 && b != 0) begin
				cx = cp * cp - ap * ap - bp * bp;
				cy = s;
				an = 0;
				if (cx < 0) begin
					t = cx;
					cx = cy;
					cy = -t;
					an = ANGLE_90;
				end
				for (int i = 0; i < CORDIC_STEPS; i++) begin
					sx = cy >>> i;
					sy = cx >>> i;
					if (cy > 0) begin
						cx = cx + sx;
						cy = cy - sy;
						an = an + ATAN_Q16[i];
					end else begin
						cx = cx - sx;
						cy = cy + sy;
						an = an - ATAN_Q16[i];
					end
				end
				if (an < 0) an = 0;
				if (an > ANGLE_180) an = ANGLE_180;
				ang = an;
			end
		end
		total = len_sum + seg;
		if (total > LEN40_SAT)
			total = LEN40_SAT;

		r.strand_number        = strand_ctr[STRAND_W-1:0];
		r.point_position       = pts_in_strand[POS_W-1:0];
		r.segment_valid        = (pts_in_strand > 0);
		r.seg_length           = seg[LEN_W-1:0];
		r.wedge_valid          = (pts_in_strand >= 2);
		r.wedge_curvature      = curv[LEN_W-1:0];
		r.wedge_turn_angle     = ang[ANGLE_W-1:0];
		r.strand_done          = done;
		r.strand_total_length  = done ? total[SUM_W-1:0] : '0;
		r.strand_segment_count = done ? pts_in_strand[POS_W-1:0] : '0;

		// advance state
		older_x = recent_x;
		older_y = recent_y;
		older_z = recent_z;
		recent_x = px;
		recent_y = py;
		recent_z = pz;
		recent_len = seg;
		if (done) begin
			pts_in_strand = 0;
			len_sum = 0;
			strand_ctr = (strand_ctr + 1) & ((64'd1 << STRAND_INDEX_BITS) - 1);
		end else begin
			pts_in_strand++;
			len_sum = total;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got, exp);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycles);
		errors++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got, exp);
		if (got !== exp)
			report_mismatch(what, got, exp);
	endtask

	// result side: random backpressure
	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= recv_stall_pct);

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		result_beat_t e;
		if (arst_n && result_valid === 1'b1 && result_ready) begin
			if (expected_metrics.size() == 0) begin
				report_mismatch("unexpected beat", result.point_position, 0);
			end else begin
				e = expected_metrics.pop_front();
				check_field("strand_number", result.strand_number, e.strand_number);
				check_field("point_position", result.point_position, e.point_position);
				check_field("segment_valid", result.segment_valid, e.segment_valid);
				check_field("seg_length", result.seg_length, e.seg_length);
				check_field("wedge_valid", result.wedge_valid, e.wedge_valid);
				check_field("wedge_curvature", result.wedge_curvature, e.wedge_curvature);
				check_field("wedge_turn_angle", result.wedge_turn_angle, e.wedge_turn_angle);
				check_field("strand_done", result.strand_done, e.strand_done);
				check_field("strand_total_length", result.strand_total_length,
					e.strand_total_length);
				check_field("strand_segment_count", result.strand_segment_count,
					e.strand_segment_count);
			end
		end
	end

	// send one point beat; called and returns at a falling edge
	task automatic send_point(input int x, y, z, input bit last);
		point_beat_t pb;
		pb.point_x = x;
		pb.point_y = y;
		pb.point_z = z;
		pb.last_in_strand = last;
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		point = pb;
		point_valid = 1'b1;
		forever begin
			#1;
			if (point_ready === 1'b1) begin
				@(posedge clk);
				break;
			end
			@(negedge clk);
		end
		expected_metrics = {expected_metrics, predict_point(pb)};
		@(negedge clk);
		point_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_metrics.size() != 0)
			@(negedge clk);
	endtask

	// single point, short strands, straight line, reversal, right angle, repeats, extremes
	task automatic test_directed();
		send_point(0, 0, 0, 1'b1);
		send_point(32'sh10000, 0, 0, 1'b0);
		send_point(32'sh30000, 32'sh40000, 0, 1'b1);
		send_point(0, 0, 0, 1'b0);
		send_point(32'sh10000, 0, 0, 1'b0);
		send_point(32'sh20000, 0, 0, 1'b0);
		send_point(32'sh10000, 0, 0, 1'b0);
		send_point(32'sh10000, 32'sh10000, 0, 1'b0);
		send_point(32'sh10000, 32'sh10000, 0, 1'b0);
		send_point(32'sh10000, 32'sh10000, 32'sh10000, 1'b1);
		// saturated lengths in the wedge
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_point(-1, 0, 1, 1'b1);
		// nearly collinear, tiny area
		send_point(0, 0, 0, 1'b0);
		send_point(32'sh7FFF_0000, 1, 0, 1'b0);
		send_point(32'sh7FFF_FFFF, 2, 0, 1'b1);
	endtask

	// long strand of saturated segments so the strand sum clamps
	task automatic test_sum_saturation();
		for (int i = 0; i < 262; i++) begin
			if (i % 2 == 0)
				send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, i == 261);
			else
				send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, i == 261);
		end
	endtask

	// random strands: random walks of several step sizes, repeats, and raw noise
	task automatic test_random_strands(input int n_points, input bit hold_once);
		int sent, len, style, x, y, z, span;
		sent = 0;
		while (sent < n_points) begin
			if (hold_once && sent > n_points / 2) begin
				wait_drained();
				hold_once = 1'b0;
			end
			len = ($urandom_range(99) < 80) ? $urandom_range(1, 10) : $urandom_range(11, 40);
			style = $urandom_range(0, 4);
			case (style)
				0: span = 0;
				1: span = 1 << 8;
				2: span = 1 << 18;
				3: span = 1 << 28;
				default: span = -1;
			endcase
			x = $urandom;
			y = $urandom;
			z = $urandom;
			for (int i = 0; i < len && sent < n_points; i++) begin
				send_point(x, y, z, (i == len - 1));
				sent++;
				if (span < 0) begin
					x = $urandom;
					y = $urandom;
					z = $urandom;
				end else if (span > 0 && $urandom_range(9) != 0) begin
					x = x + $urandom_range(0, 2 * span) - span;
					y = y + $urandom_range(0, 2 * span) - span;
					z = z + $urandom_range(0, 2 * span) - span;
				end else if ($urandom_range(3) == 0) begin
					x = x + $urandom_range(0, 2) - 1;
				end
			end
		end
	endtask

	initial begin
		older_x = 0; older_y = 0; older_z = 0;
		recent_x = 0; recent_y = 0; recent_z = 0;
		recent_len = 0;
		len_sum = 0;
		pts_in_strand = 0;
		strand_ctr = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_sum_saturation();
		test_random_strands(400, 1'b1);
		send_idle_pct = 85;
		test_random_strands(400, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 85;
		test_random_strands(400, 1'b0);
		send_idle_pct = 25;
		recv_stall_pct = 25;
		test_random_strands(270, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
